// ===== rtl/core/itf_pkg.sv =====
package itf_pkg;

  // Operation codes carried in the command field.
  localparam logic [1:0] CMD_UDEC = 2'd0;
  localparam logic [1:0] CMD_SDEC = 2'd1;
  localparam logic [1:0] CMD_HEX  = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [3:0] DEC_MAX_DIGIT = 4'd9;
  localparam logic [7:0] HEX_TEN = 8'h0A;

  typedef struct packed {
    logic hex;
    logic neg;
  } itf_ctl_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] r;
    if (d <= DEC_MAX_DIGIT) begin
      r = CH_ZERO + {4'd0, d};
    end else begin
      r = CH_UPPER_A + {4'd0, d} - HEX_TEN;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/itf_if.sv =====
interface itf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface itf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== rtl/core/itf_front.sv =====
module itf_front #(
  parameter int VALUE_BITS = 32
) (
  itf_in_if.sink                          in_ch,
  input  logic                            fifo_full,
  output logic                            push,
  output itf_pkg::itf_ctl_t               ctl,
  output logic [((VALUE_BITS+3)/4)*4-1:0] mag
);
  import itf_pkg::*;

  localparam int OPW = ((VALUE_BITS + 3) / 4) * 4;
  localparam int CW  = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  logic [VALUE_BITS-1:0] opv;
  logic [VALUE_BITS-1:0] neg_v;
  logic                  known;
  logic                  is_neg;

  // Bits above the operand width are ignored.
  assign opv    = VALUE_BITS'(in_ch.value[CW-1:0]);
  assign is_neg = (in_ch.command == CMD_SDEC) && opv[VALUE_BITS-1];
  // Modulo negation gives the exact magnitude of the most negative value.
  assign neg_v  = ~opv + VALUE_BITS'(1);

  assign known = (in_ch.command == CMD_UDEC) || (in_ch.command == CMD_SDEC) ||
                 (in_ch.command == CMD_HEX);

  // The unused command code is taken and dropped.
  assign in_ch.ready = !fifo_full;
  assign push        = in_ch.valid && !fifo_full && known;
  assign ctl.hex     = (in_ch.command == CMD_HEX);
  assign ctl.neg     = is_neg;
  assign mag         = OPW'(is_neg ? neg_v : opv);

endmodule

// ===== rtl/core/itf_fifo.sv =====
module itf_fifo #(
  parameter int W = 34
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

// ===== rtl/core/itf_back.sv =====
module itf_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fifo_empty,
  output logic                            pop,
  input  itf_pkg::itf_ctl_t               job_ctl,
  input  logic [((VALUE_BITS+3)/4)*4-1:0] job_mag,
  itf_out_if.source                       out_ch
);
  import itf_pkg::*;

  localparam int NIB  = (VALUE_BITS + 3) / 4;
  localparam int OPW  = NIB * 4;
  localparam int DIGS = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int BW   = DIGS * 4;
  localparam int IW   = $clog2(DIGS);
  localparam int CNTW = $clog2(NIB + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_LEAD = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]      st_r, st_nxt;
  itf_ctl_t        ctl_r, ctl_nxt;
  logic [OPW-1:0]  mag_r, mag_nxt;
  logic [BW-1:0]   bcd_r, bcd_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [1:0]      pfx_r, pfx_nxt;
  logic            ov_r, ov_nxt;
  logic [7:0]      ch_r, ch_nxt;
  logic            last_r, last_nxt;

  logic [IW-1:0]   lead;
  logic [7:0]      nch;
  logic            nlast;
  logic            take;
  logic            room;

  // Four shift-and-add-3 steps: folds the next operand nibble into the BCD digits.
  function automatic logic [BW-1:0] dab4(input logic [BW-1:0] b, input logic [3:0] bits);
    logic [BW-1:0] t;
    int s;
    int i;
    t = b;
    for (s = 0; s < 4; s++) begin
      for (i = 0; i < DIGS; i++) begin
        if (t[i*4 +: 4] >= 4'd5) begin
          t[i*4 +: 4] = t[i*4 +: 4] + 4'd3;
        end
      end
      t = {t[BW-2:0], bits[3-s]};
    end
    return t;
  endfunction

  // Highest nonzero digit; a zero value still prints one digit.
  always_comb begin
    lead = '0;
    for (int i = 0; i < DIGS; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        lead = IW'(i);
      end
    end
  end

  always_comb begin
    if (pfx_r != 2'd0) begin
      if (ctl_r.hex) begin
        nch = (pfx_r == 2'd2) ? CH_ZERO : CH_X;
      end else begin
        nch = CH_MINUS;
      end
      nlast = 1'b0;
    end else begin
      nch   = digit_char(bcd_r[int'(idx_r)*4 +: 4]);
      nlast = (idx_r == '0);
    end
  end

  assign take = ov_r && out_ch.ready;
  assign room = !ov_r || out_ch.ready;

  always_comb begin
    st_nxt   = st_r;
    ctl_nxt  = ctl_r;
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    pfx_nxt  = pfx_r;
    ov_nxt   = take ? 1'b0 : ov_r;
    ch_nxt   = ch_r;
    last_nxt = last_r;
    pop      = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (!fifo_empty) begin
          pop     = 1'b1;
          ctl_nxt = job_ctl;
          mag_nxt = job_mag;
          cnt_nxt = CNTW'(NIB);
          if (job_ctl.hex) begin
            bcd_nxt = BW'(job_mag);
            st_nxt  = ST_LEAD;
          end else begin
            bcd_nxt = '0;
            st_nxt  = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        bcd_nxt = dab4(bcd_r, mag_r[OPW-1 -: 4]);
        mag_nxt = mag_r << 4;
        cnt_nxt = cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          st_nxt = ST_LEAD;
        end
      end
      ST_LEAD: begin
        idx_nxt = lead;
        pfx_nxt = ctl_r.hex ? 2'd2 : (ctl_r.neg ? 2'd1 : 2'd0);
        st_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (room) begin
          ov_nxt   = 1'b1;
          ch_nxt   = nch;
          last_nxt = nlast;
          if (pfx_r != 2'd0) begin
            pfx_nxt = pfx_r - 2'd1;
          end else if (idx_r != '0) begin
            idx_nxt = idx_r - IW'(1);
          end
          if (nlast) begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r  <= ctl_nxt;
    mag_r  <= mag_nxt;
    bcd_r  <= bcd_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    pfx_r  <= pfx_nxt;
    ch_r   <= ch_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.char_code = ch_r;
  assign out_ch.last_char = last_r;

  a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_CONV |-> cnt_r != '0)
    else $error("conversion running with an exhausted nibble count");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> st_r == ST_IDLE)
    else $error("queue popped while a number is still in progress");

  a_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !last_r |-> st_r == ST_EMIT)
    else $error("text left unfinished outside the emit state");

  a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_EMIT && room && nlast |=> ov_r && last_r && st_r == ST_IDLE)
    else $error("final character not presented when the text ends");

endmodule

// ===== rtl/core/integer_to_ascii_formatter_core.sv =====
// Channel | Direction | Payload                    | Handshake
// in_ch   | sink      | command[1:0], value[31:0]  | valid/ready
// out_ch  | source    | char_code[7:0], last_char  | valid/ready
//
// A number leaves the queue, goes through BCD conversion (decimal only, four
// operand bits per cycle), has its leading digit found, and then has its
// characters emitted in turn.
// A two-entry queue lets two more numbers be taken while one prints.
// Reset is synchronous and clears the queue and the output valid register.
// A low out_ch.ready holds the current character; in_ch.ready drops when the
// queue is full. Command 3 is taken and yields no characters.
module integer_to_ascii_formatter_core #(
  parameter int VALUE_BITS = 32
) (
  input logic       clk,
  input logic       rst_n,
  itf_in_if.sink    in_ch,
  itf_out_if.source out_ch
);
  import itf_pkg::*;

  localparam int OPW = ((VALUE_BITS + 3) / 4) * 4;
  localparam int CTW = $bits(itf_ctl_t);
  localparam int QW  = CTW + OPW;

  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  itf_ctl_t       f_ctl;
  logic [OPW-1:0] f_mag;
  logic [QW-1:0]  q_out;
  itf_ctl_t       b_ctl;
  logic [OPW-1:0] b_mag;

  itf_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .in_ch     (in_ch),
    .fifo_full (full),
    .push      (push),
    .ctl       (f_ctl),
    .mag       (f_mag)
  );

  itf_fifo #(.W(QW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   ({f_ctl, f_mag}),
    .full  (full),
    .pop   (pop),
    .dout  (q_out),
    .empty (empty)
  );

  assign b_ctl = itf_ctl_t'(q_out[QW-1 -: CTW]);
  assign b_mag = q_out[OPW-1:0];

  itf_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (empty),
    .pop        (pop),
    .job_ctl    (b_ctl),
    .job_mag    (b_mag),
    .out_ch     (out_ch)
  );

endmodule
